>>> rtl/fur_pkg.sv
// Package for the frame upload receiver: command, event and error codes,
// the classified work item passed from front to back, and the CRC-32 byte step.
// No dependencies.
package fur_pkg;

	localparam int FRAME_BYTES_MAX_DEF = 131072;

	localparam logic [2:0] CMD_START  = 3'd0;
	localparam logic [2:0] CMD_COMMIT = 3'd1;
	localparam logic [2:0] CMD_ABORT  = 3'd2;
	localparam logic [2:0] CMD_OTHER  = 3'd3;
	localparam logic [2:0] CMD_HEADER = 3'd4;
	localparam logic [2:0] CMD_BYTE   = 3'd5;
	localparam logic [2:0] CMD_CANCEL = 3'd6;
	localparam logic [2:0] CMD_DONE   = 3'd7;

	localparam logic [15:0] START_MSG_LEN  = 16'd10;
	localparam logic [15:0] COMMIT_MSG_LEN = 16'd1;
	localparam logic [15:0] CHUNK_HDR_LEN  = 16'd4;
	localparam logic [7:0]  FORMAT_ACCEPTED = 8'h01;

	localparam logic [2:0] EV_READY     = 3'd0;
	localparam logic [2:0] EV_PROGRESS  = 3'd1;
	localparam logic [2:0] EV_VERIFIED  = 3'd2;
	localparam logic [2:0] EV_DISPLAYED = 3'd3;
	localparam logic [2:0] EV_ERROR     = 3'd4;
	localparam logic [2:0] EV_NONE      = 3'd5;

	localparam logic [3:0] E_NONE        = 4'd0;
	localparam logic [3:0] E_INVALID     = 4'd1;
	localparam logic [3:0] E_FORMAT      = 4'd2;
	localparam logic [3:0] E_SIZE        = 4'd3;
	localparam logic [3:0] E_BUSY        = 4'd4;
	localparam logic [3:0] E_NO_TRANSFER = 4'd5;
	localparam logic [3:0] E_OFFSET      = 4'd6;
	localparam logic [3:0] E_OVERFLOW    = 4'd7;
	localparam logic [3:0] E_INCOMPLETE  = 4'd8;
	localparam logic [3:0] E_CRC         = 4'd9;
	localparam logic [3:0] E_STORAGE     = 4'd10;
	localparam logic [3:0] E_DISPLAY     = 4'd11;
	localparam logic [3:0] E_COOLDOWN    = 4'd12;

	localparam logic [1:0] REG_REQUIRED_SIZE     = 2'd0;
	localparam logic [1:0] REG_PROGRESS_INTERVAL = 2'd1;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] msg_length;
		logic [7:0]  image_format;
		logic [31:0] image_size;
		logic [31:0] expected_crc;
		logic [31:0] chunk_offset;
		logic [7:0]  data_byte;
		logic        display_refreshing;
		logic [15:0] cooldown_seconds;
		logic        handoff_ok;
		logic        save_ok;
		logic        display_ok;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic [3:0]  error_code;
		logic [31:0] result_value;
		logic        write_valid;
		logic [16:0] write_address;
		logic [7:0]  write_byte;
		logic        show_frame;
		logic        last;
	} out_item_t;

	// Classified work item: the front resolves checks that need no transfer state.
	typedef struct packed {
		logic        bad_len;
		logic        start_bad_fmt;
		logic        start_bad_size;
		in_item_t    item;
	} work_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ (32'hEDB88320 & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

>>> rtl/fur_if.sv
// Valid/ready channel interfaces for items, results and register writes.
// Depends on fur_pkg.
interface fur_in_if;
	logic              valid;
	logic              ready;
	fur_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fur_out_if;
	logic               valid;
	logic               ready;
	fur_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fur_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/fur_front.sv
// Front end: accepts items, classifies message length and start checks,
// and pushes work into a two-entry queue. Depends on fur_pkg and fur_if.
module fur_front #(
	parameter int FRAME_BYTES_MAX = fur_pkg::FRAME_BYTES_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fur_in_if.sink            in_ch,
	input  logic [17:0]       required_size,
	output logic              work_valid,
	output fur_pkg::work_t    work,
	input  logic              work_pop
);
	import fur_pkg::*;

	work_t    q_q [2];
	logic     rd_q, wr_q;
	logic [1:0] cnt_q;
	work_t    cls;
	logic     push;
	logic [2:0] cmd;
	logic [15:0] len;

	always_comb begin
		cmd = in_ch.data.command;
		len = in_ch.data.msg_length;
		cls.item = in_ch.data;
		cls.bad_len = 1'b0;
		case (cmd)
			CMD_START:  cls.bad_len = (len != START_MSG_LEN);
			CMD_COMMIT: cls.bad_len = (len != COMMIT_MSG_LEN);
			CMD_ABORT:  cls.bad_len = (len == 16'd0);
			CMD_OTHER:  cls.bad_len = 1'b1;
			CMD_HEADER: cls.bad_len = (len < CHUNK_HDR_LEN);
			default:    cls.bad_len = 1'b0;
		endcase
		cls.start_bad_fmt = (in_ch.data.image_format != FORMAT_ACCEPTED);
		cls.start_bad_size = (in_ch.data.image_size != {14'd0, required_size})
			|| ({14'd0, required_size} > 32'(FRAME_BYTES_MAX));
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign work_valid = (cnt_q != 2'd0);
	assign work = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (work_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, work_pop};
		end
	end
endmodule

>>> rtl/fur_back.sv
// Back end: transfer state, CRC and counters; emits up to two results per
// work item into a two-entry output buffer. Depends on fur_pkg and fur_if.
module fur_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              work_valid,
	input  fur_pkg::work_t    work,
	output logic              work_pop,
	input  logic [17:0]       required_size,
	input  logic [16:0]       progress_interval,
	fur_out_if.source         out_ch
);
	import fur_pkg::*;

	logic        active_q;
	logic [17:0] received_q, left_q;
	logic [18:0] mark_q;
	logic [31:0] acrc_q, crc_q;
	out_item_t   ob_q [2];
	logic        ord_q, owr_q;
	logic [1:0]  ocnt_q;

	in_item_t    it;
	out_item_t   r0, r1;
	logic [1:0]  nres;
	logic        do_end, do_start, do_byte, set_left, set_mark;
	logic [17:0] new_left, rcv_inc, remaining, nlen;
	logic [18:0] new_mark;
	logic [31:0] crc_inv, crc_nxt;
	logic        due_hdr, due_byte;
	logic [1:0]  pops;

	function automatic out_item_t err(input logic [3:0] e, input logic [31:0] v);
		out_item_t o;
		o = '0;
		o.event_code = EV_ERROR;
		o.error_code = e;
		o.result_value = v;
		o.last = 1'b1;
		return o;
	endfunction

	always_comb begin
		it = work.item;
		r0 = '0;
		r1 = '0;
		nres = 2'd0;
		do_end = 1'b0;
		do_start = 1'b0;
		do_byte = 1'b0;
		set_left = 1'b0;
		set_mark = 1'b0;
		new_left = '0;
		new_mark = '0;
		crc_inv = ~crc_q;
		crc_nxt = crc_byte(crc_q, it.data_byte);
		rcv_inc = received_q + 18'd1;
		remaining = (required_size > received_q) ? required_size - received_q : 18'd0;
		nlen = {2'd0, it.msg_length - CHUNK_HDR_LEN};
		due_hdr = ({1'b0, received_q} >= mark_q) || (received_q == required_size);
		due_byte = ({1'b0, rcv_inc} >= mark_q) || (rcv_inc == required_size);
		if (work.bad_len) begin
			r0 = err(E_INVALID, 32'd0);
			nres = 2'd1;
			do_end = 1'b1;
		end else begin
			case (it.command)
				CMD_START: begin
					nres = 2'd1;
					do_end = 1'b1;
					if (work.start_bad_fmt) begin
						r0 = err(E_FORMAT, {24'd0, it.image_format});
					end else if (work.start_bad_size) begin
						r0 = err(E_SIZE, {14'd0, required_size});
					end else if (it.display_refreshing) begin
						r0 = err(E_BUSY, 32'd0);
					end else if (it.cooldown_seconds != 16'd0) begin
						r0 = err(E_COOLDOWN, {16'd0, it.cooldown_seconds});
					end else begin
						do_start = 1'b1;
						r0.event_code = EV_READY;
						r0.result_value = it.image_size;
						r0.last = 1'b1;
					end
				end
				CMD_COMMIT: begin
					nres = 2'd1;
					do_end = 1'b1;
					if (!active_q) begin
						r0 = err(E_NO_TRANSFER, 32'd0);
					end else if (received_q != required_size) begin
						r0 = err(E_INCOMPLETE, {14'd0, received_q});
					end else if (crc_inv != acrc_q) begin
						r0 = err(E_CRC, crc_inv);
					end else if (it.display_refreshing) begin
						r0 = err(E_BUSY, 32'd0);
					end else if (it.cooldown_seconds != 16'd0) begin
						r0 = err(E_COOLDOWN, {16'd0, it.cooldown_seconds});
					end else begin
						r0.event_code = EV_VERIFIED;
						r0.result_value = {14'd0, required_size};
						r0.show_frame = 1'b1;
						r0.last = it.handoff_ok;
						if (!it.handoff_ok) begin
							r1 = err(E_BUSY, 32'd0);
							nres = 2'd2;
						end
					end
				end
				CMD_ABORT, CMD_CANCEL: begin
					do_end = 1'b1;
				end
				CMD_HEADER: begin
					if (!active_q) begin
						r0 = err(E_NO_TRANSFER, 32'd0);
						nres = 2'd1;
						do_end = 1'b1;
					end else if (it.chunk_offset != {14'd0, received_q}) begin
						r0 = err(E_OFFSET, {14'd0, received_q});
						nres = 2'd1;
						do_end = 1'b1;
					end else if (nlen > remaining) begin
						r0 = err(E_OVERFLOW, {14'd0, required_size});
						nres = 2'd1;
						do_end = 1'b1;
					end else begin
						set_left = 1'b1;
						new_left = nlen;
						if (nlen == 18'd0 && due_hdr) begin
							set_mark = 1'b1;
							new_mark = {1'b0, received_q} + {2'd0, progress_interval};
							r0.event_code = EV_PROGRESS;
							r0.result_value = {14'd0, received_q};
							r0.last = 1'b1;
							nres = 2'd1;
						end
					end
				end
				CMD_BYTE: begin
					if (active_q && left_q != 18'd0) begin
						do_byte = 1'b1;
						nres = 2'd1;
						r0.write_valid = 1'b1;
						r0.write_address = received_q[16:0];
						r0.write_byte = it.data_byte;
						r0.last = 1'b1;
						r0.event_code = EV_NONE;
						if (left_q == 18'd1 && due_byte) begin
							set_mark = 1'b1;
							new_mark = {1'b0, rcv_inc} + {2'd0, progress_interval};
							r0.event_code = EV_PROGRESS;
							r0.result_value = {14'd0, rcv_inc};
						end
					end
				end
				default: begin
					nres = 2'd1;
					r0.last = 1'b1;
					if (!it.display_ok) begin
						r0.event_code = EV_ERROR;
						r0.error_code = E_DISPLAY;
					end else begin
						r0.event_code = EV_DISPLAYED;
						r0.error_code = it.save_ok ? E_NONE : E_STORAGE;
					end
				end
			endcase
		end
	end

	// Space is needed for up to two results; a single free slot takes one.
	assign pops = {1'b0, out_ch.valid && out_ch.ready};
	assign work_pop = work_valid && ((ocnt_q == 2'd0) ||
		(ocnt_q == 2'd1 && nres != 2'd2) || (ocnt_q == 2'd1 && pops != 2'd0));
	assign out_ch.valid = (ocnt_q != 2'd0);
	assign out_ch.data = ob_q[ord_q];

	always_ff @(posedge clk) begin
		if (work_pop && nres != 2'd0) begin
			ob_q[owr_q] <= r0;
			if (nres == 2'd2) ob_q[~owr_q] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_q <= 1'b0;
			owr_q <= 1'b0;
			ocnt_q <= 2'd0;
			active_q <= 1'b0;
			received_q <= '0;
			mark_q <= '0;
			left_q <= '0;
			acrc_q <= '0;
			crc_q <= '1;
		end else begin
			if (pops != 2'd0) ord_q <= ~ord_q;
			if (work_pop) begin
				owr_q <= owr_q ^ nres[0];
				ocnt_q <= ocnt_q + nres - pops;
				if (do_end) begin
					active_q <= 1'b0;
					received_q <= '0;
					left_q <= '0;
					crc_q <= '1;
				end
				if (do_start) begin
					active_q <= 1'b1;
					acrc_q <= it.expected_crc;
					mark_q <= {2'd0, progress_interval};
				end
				if (set_left) left_q <= new_left;
				if (set_mark) mark_q <= new_mark;
				if (do_byte) begin
					crc_q <= crc_nxt;
					received_q <= rcv_inc;
					left_q <= left_q - 18'd1;
				end
			end else begin
				ocnt_q <= ocnt_q - pops;
			end
		end
	end
endmodule

>>> rtl/frame_upload_receiver_top.sv
// Frame upload receiver top level: register port, front classifier and
// back executor. Depends on fur_pkg, fur_if, fur_front and fur_back.
//
// Channels: in_ch carries one command per beat, out_ch one result per beat,
// cfg_ch writes required_size (index 0) and the progress interval (index 1).
// A command beat enters a two-entry queue in the front; the back takes one
// queued command per cycle when its two-entry result buffer has room.
// A command beat passes through the front queue register and then the back's
// result buffer register before its result beat can be taken.
// Throughput is one command per cycle while the result buffer has room, with the
// CRC-32 byte update and counter step done combinationally in the back; a commit
// refused by the display yields two results and occupies both buffer entries.
// Reset clears the transfer, both queues and the registers to their defaults.
// When the result receiver stalls, the buffer fills, the back stops taking
// commands and in_ch ready falls once the front queue is full.
// Register writes are accepted at any time and are registered before they take effect.
module frame_upload_receiver_top #(
	parameter int FRAME_BYTES_MAX = fur_pkg::FRAME_BYTES_MAX_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	fur_in_if.sink    in_ch,
	fur_out_if.source out_ch,
	fur_cfg_if.sink   cfg_ch
);
	import fur_pkg::*;

	logic [17:0] required_size_q;
	logic [16:0] progress_interval_q;
	logic        work_valid, work_pop;
	work_t       work;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			required_size_q <= 18'd131072;
			progress_interval_q <= 17'd8192;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_REQUIRED_SIZE: required_size_q <= cfg_ch.wdata[17:0];
				REG_PROGRESS_INTERVAL: progress_interval_q <= cfg_ch.wdata[16:0];
				default: ;
			endcase
		end
	end

	fur_front #(.FRAME_BYTES_MAX(FRAME_BYTES_MAX)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .required_size(required_size_q),
		.work_valid(work_valid), .work(work), .work_pop(work_pop)
	);

	fur_back u_back (
		.clk(clk), .arst_n(arst_n), .work_valid(work_valid), .work(work),
		.work_pop(work_pop), .required_size(required_size_q),
		.progress_interval(progress_interval_q), .out_ch(out_ch)
	);
endmodule
